// ===== rtl/rks_pkg.sv =====
package rks_pkg;

	localparam int KEY_W           = 32;
	localparam int TAG_W           = 6;
	localparam int MAX_RECORDS_DEF = 64;

	typedef struct packed {
		logic [KEY_W-1:0] record_key;
		logic [TAG_W-1:0] record_tag;
		logic             set_last;
	} load_beat_t;

	typedef struct packed {
		logic [KEY_W-1:0] sorted_key;
		logic [TAG_W-1:0] sorted_tag;
		logic             out_last;
	} sort_beat_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} cell_rec_t;

	// chain-wide command to every cell
	typedef struct packed {
		logic insert;
		logic drain;
	} cell_ctrl_t;

endpackage

// ===== rtl/rks_cell.sv =====
module rks_cell
	import rks_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  cell_rec_t  new_rec,
	input  logic       prev_place,
	input  logic       prev_occ,
	input  cell_rec_t  prev_rec,
	input  logic       next_occ,
	input  cell_rec_t  next_rec,
	output logic       occ,
	output cell_rec_t  rec,
	output logic       place
);

	logic      occ_q;
	cell_rec_t rec_q;

	// strict compare keeps equal keys in load order
	assign place = !occ_q || (rec_q.key > new_rec.key);
	assign occ   = occ_q;
	assign rec   = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.drain) begin
			occ_q <= next_occ;
		end else if (ctrl.insert && place) begin
			occ_q <= prev_place ? prev_occ : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			rec_q <= next_rec;
		end else if (ctrl.insert && place) begin
			rec_q <= prev_place ? prev_rec : new_rec;
		end
	end

endmodule

// ===== rtl/record_key_sorter.sv =====
// Stable ascending sorter for sets of up to MAX_RECORDS records.
// Load channel: one record beat per cycle while load_stall is low (key, tag,
// set_last). Each beat is dropped into its sorted place in a row of cells in
// the cycle it is taken, so loading keeps that rate. A record arriving while
// the row is full is discarded; its set_last still closes the set.
// Once the set_last beat is taken, load_stall rises and the row shifts out
// towards the sort channel, one record per cycle while sort_stall is low.
// After the set_last beat is taken, drain_q is set, and the head cell then
// moves into the output register: the first sorted beat shows on sort_*,
// with out_last on the final beat. load_stall falls as the final record
// leaves the row, so the next set may load while that last beat still waits.
// A stalled sort beat holds in the output register and pauses the shift.
// Reset empties the row, clears the fill count and drops any pending beat;
// no clearing pass is needed.
module record_key_sorter
	import rks_pkg::*;
#(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load_valid,
	output logic       load_stall,
	input  load_beat_t load_beat,
	output logic       sort_valid,
	input  logic       sort_stall,
	output sort_beat_t sort_beat
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] remain_q;
	logic             drain_q;
	logic             out_valid_q;
	sort_beat_t       out_q;

	logic       load_take;
	logic       full;
	logic       out_free;
	cell_ctrl_t ctrl;
	cell_rec_t  new_rec;

	logic      occ   [MAX_RECORDS];
	logic      place [MAX_RECORDS];
	cell_rec_t rec   [MAX_RECORDS];

	assign load_stall = drain_q;
	assign load_take  = load_valid && !drain_q;
	assign full       = (fill_q == CNT_W'(MAX_RECORDS));
	assign out_free   = !out_valid_q || !sort_stall;

	assign ctrl.insert = load_take && !full;
	assign ctrl.drain  = drain_q && out_free;

	assign new_rec.key = load_beat.record_key;
	assign new_rec.tag = load_beat.record_tag;

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		logic      prev_place_w;
		logic      prev_occ_w;
		cell_rec_t prev_rec_w;
		logic      next_occ_w;
		cell_rec_t next_rec_w;

		if (i == 0) begin : g_head
			assign prev_place_w = 1'b0;
			assign prev_occ_w   = 1'b0;
			assign prev_rec_w   = '0;
		end else begin : g_body
			assign prev_place_w = place[i-1];
			assign prev_occ_w   = occ[i-1];
			assign prev_rec_w   = rec[i-1];
		end

		if (i == MAX_RECORDS - 1) begin : g_tail
			assign next_occ_w = 1'b0;
			assign next_rec_w = '0;
		end else begin : g_mid
			assign next_occ_w = occ[i+1];
			assign next_rec_w = rec[i+1];
		end

		rks_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_rec    (new_rec),
			.prev_place (prev_place_w),
			.prev_occ   (prev_occ_w),
			.prev_rec   (prev_rec_w),
			.next_occ   (next_occ_w),
			.next_rec   (next_rec_w),
			.occ        (occ[i]),
			.rec        (rec[i]),
			.place      (place[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			remain_q    <= '0;
			drain_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_take) begin
				if (load_beat.set_last) begin
					drain_q  <= 1'b1;
					remain_q <= full ? fill_q : fill_q + CNT_W'(1);
				end else if (!full) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end

			if (ctrl.drain) begin
				out_valid_q <= 1'b1;
				remain_q    <= remain_q - CNT_W'(1);
				if (remain_q == CNT_W'(1)) begin
					drain_q <= 1'b0;
					fill_q  <= '0;
				end
			end else if (!sort_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// head cell feeds the output register
	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			out_q.sorted_key <= rec[0].key;
			out_q.sorted_tag <= rec[0].tag;
			out_q.out_last   <= (remain_q == CNT_W'(1));
		end
	end

	assign sort_valid = out_valid_q;
	assign sort_beat  = out_q;

endmodule
